@@ hdl/tkhm_pkg.sv @@
// Shared types, widths and helpers for the touch key history matcher.
`timescale 1ns / 1ps
package tkhm_pkg;

	localparam int FAULT_W      = 3;
	localparam int STATUS_W     = 8;
	localparam int KEY_W        = 4;
	localparam int CODE_NIBBLES = 8;
	localparam int APB_DATA_W   = 32;
	localparam int APB_ADDR_W   = 3;

	typedef logic [KEY_W-1:0]      key_t;
	typedef logic [FAULT_W-1:0]    fault_t;
	typedef logic [STATUS_W-1:0]   status_t;
	typedef logic [APB_DATA_W-1:0] apb_data_t;
	typedef logic [APB_ADDR_W-1:0] apb_addr_t;

	// register index, taken from the word address bit of paddr
	typedef enum logic [0:0] {
		REG_SECRET_CODE = 1'b0
	} reg_idx_t;

	// slide gestures, newest entry first
	localparam key_t GEST_LEFT_UP    [4] = '{4'd1, 4'd2, 4'd3, 4'd4};
	localparam key_t GEST_LEFT_DOWN  [4] = '{4'd4, 4'd3, 4'd2, 4'd1};
	localparam key_t GEST_RIGHT_UP   [4] = '{4'd5, 4'd6, 4'd7, 4'd8};
	localparam key_t GEST_RIGHT_DOWN [4] = '{4'd8, 4'd7, 4'd6, 4'd5};

	// single set bit gives its pad number (1..8), several bits give 0
	function automatic key_t decode_status(input status_t status);
		key_t k;
		k = '0;
		for (int b = 0; b < STATUS_W; b++) begin
			if (status == status_t'(1 << b))
				k = key_t'(b + 1);
		end
		return k;
	endfunction

endpackage

@@ hdl/tkhm_in_if.sv @@
// Touch event channel: valid/ready with fault and pad status payload.
`timescale 1ns / 1ps
interface tkhm_in_if;
	import tkhm_pkg::*;

	logic    valid;
	logic    ready;
	fault_t  fault_flags;
	status_t touch_status;

	modport source (output valid, output fault_flags, output touch_status, input ready);
	modport sink   (input valid, input fault_flags, input touch_status, output ready);
endinterface

@@ hdl/tkhm_out_if.sv @@
// Result channel: valid/ready with key and gesture flags.
`timescale 1ns / 1ps
interface tkhm_out_if;
	import tkhm_pkg::*;

	logic valid;
	logic ready;
	logic key_pressed;
	key_t key_number;
	logic slide_left_up;
	logic slide_left_down;
	logic slide_right_up;
	logic slide_right_down;
	logic code_match;

	modport source (
		output valid, output key_pressed, output key_number,
		output slide_left_up, output slide_left_down,
		output slide_right_up, output slide_right_down,
		output code_match, input ready
	);
	modport sink (
		input valid, input key_pressed, input key_number,
		input slide_left_up, input slide_left_down,
		input slide_right_up, input slide_right_down,
		input code_match, output ready
	);
endinterface

@@ hdl/tkhm_cell.sv @@
// One history cell: holds a key entry, shifts from its neighbour, checks its code nibble.
`timescale 1ns / 1ps
module tkhm_cell
	import tkhm_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic shift,
	input  key_t din,
	input  key_t nibble,
	output key_t entry,
	output key_t entry_nxt,
	output logic match
);

	key_t entry_q;

	assign entry_nxt = shift ? din : entry_q;
	assign entry     = entry_q;
	// zero nibble is a wildcard
	assign match     = (nibble == '0) || (nibble == entry_nxt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			entry_q <= '0;
		else
			entry_q <= entry_nxt;
	end

endmodule

@@ hdl/touch_key_history_matcher.sv @@
// Top level: APB code register, row of history cells, registered result stage.
`timescale 1ns / 1ps
// Result valid rises in the cycle after an event transfer (result register).
// Throughput: one event per cycle; a new event is taken while the result
// register is empty or being drained in the same cycle.
// The history row shifts once per clean event with a non-zero pad status.
// Reset clears the history, last key, code register and result valid.
module touch_key_history_matcher
	import tkhm_pkg::*;
#(
	parameter int HISTORY_DEPTH = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	tkhm_in_if.sink     evt,
	tkhm_out_if.source  res,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  apb_addr_t   paddr,
	input  apb_data_t   pwdata,
	output apb_data_t   prdata,
	output logic        pready
);

	apb_data_t code_q;
	key_t      last_key_q;
	logic      res_valid_q;
	logic      pressed_q;
	logic      lu_q, ld_q, ru_q, rd_q, match_q;

	logic      take;
	logic      push;
	key_t      key_dec;
	key_t      cell_din   [HISTORY_DEPTH];
	key_t      cell_entry [HISTORY_DEPTH];
	key_t      cell_nxt   [HISTORY_DEPTH];
	key_t      cell_nib   [HISTORY_DEPTH];
	logic [HISTORY_DEPTH-1:0] cell_match;
	logic      lu_d, ld_d, ru_d, rd_d;

	// configuration port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_SECRET_CODE) ? code_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			code_q <= '0;
		else if (psel && penable && pwrite && (paddr[2] == REG_SECRET_CODE))
			code_q <= pwdata;
	end

	// event intake
	assign evt.ready = !res_valid_q || res.ready;
	assign take      = evt.valid && evt.ready;
	assign push      = take && (evt.fault_flags == '0) && (evt.touch_status != '0);
	assign key_dec   = decode_status(evt.touch_status);

	// history row, cell 0 newest
	for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign cell_din[i] = key_dec;
		end else begin : g_body
			assign cell_din[i] = cell_entry[i-1];
		end
		if (i < CODE_NIBBLES) begin : g_nib
			assign cell_nib[i] = code_q[KEY_W*i +: KEY_W];
		end else begin : g_nonib
			assign cell_nib[i] = '0;
		end
		tkhm_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.shift     (push),
			.din       (cell_din[i]),
			.nibble    (cell_nib[i]),
			.entry     (cell_entry[i]),
			.entry_nxt (cell_nxt[i]),
			.match     (cell_match[i])
		);
	end

	always_comb begin
		lu_d = 1'b1;
		ld_d = 1'b1;
		ru_d = 1'b1;
		rd_d = 1'b1;
		for (int g = 0; g < 4; g++) begin
			lu_d &= (cell_nxt[g] == GEST_LEFT_UP[g]);
			ld_d &= (cell_nxt[g] == GEST_LEFT_DOWN[g]);
			ru_d &= (cell_nxt[g] == GEST_RIGHT_UP[g]);
			rd_d &= (cell_nxt[g] == GEST_RIGHT_DOWN[g]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			last_key_q <= '0;
		else if (push)
			last_key_q <= key_dec;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (take)
			res_valid_q <= 1'b1;
		else if (res.ready)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pressed_q <= push;
			lu_q      <= lu_d;
			ld_q      <= ld_d;
			ru_q      <= ru_d;
			rd_q      <= rd_d;
			match_q   <= &cell_match;
		end
	end

	assign res.valid            = res_valid_q;
	assign res.key_pressed      = pressed_q;
	assign res.key_number       = last_key_q;
	assign res.slide_left_up    = lu_q;
	assign res.slide_left_down  = ld_q;
	assign res.slide_right_up   = ru_q;
	assign res.slide_right_down = rd_q;
	assign res.code_match       = match_q;

	a_fault_no_press: assert property (@(posedge clk) disable iff (!arst_n)
		take && (evt.fault_flags != '0) |=> res.valid && !res.key_pressed)
		else $error("faulty event reported as pressed");

	a_push_head: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> (cell_entry[0] == last_key_q) && res.key_pressed)
		else $error("newest history entry differs from last key");

	a_hold_history: assert property (@(posedge clk) disable iff (!arst_n)
		!push |=> $stable(last_key_q) && (cell_entry[0] == $past(cell_entry[0])))
		else $error("history moved without a clean touch");

	a_slide_excl: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> $onehot0({lu_q, ld_q, ru_q, rd_q}))
		else $error("several slide gestures at once");

	a_key_range: assert property (@(posedge clk) disable iff (!arst_n)
		last_key_q <= key_t'(STATUS_W))
		else $error("last key out of range");

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for the touch key history matcher: events, results and code register.
`timescale 1ns / 1ps
module testbench;
	import tkhm_pkg::*;

	localparam int HIST_LEN = 8;
	localparam int PHASES = 8;
	localparam int PHASE_EVENTS = 250;
	localparam int LONG_STALL = 400;
	localparam apb_addr_t CODE_ADDR = apb_addr_t'(REG_SECRET_CODE) << 2;
	// one word past the last register: writes there must be dropped
	localparam apb_addr_t SPARE_ADDR = CODE_ADDR + apb_addr_t'(4);

	typedef struct packed {
		logic key_pressed;
		key_t key_number;
		logic slide_left_up;
		logic slide_left_down;
		logic slide_right_up;
		logic slide_right_down;
		logic code_match;
	} touch_result_t;

	typedef struct packed {
		fault_t        fault;
		status_t       status;
		logic          typed;
		touch_result_t want;
	} touch_row_t;

	logic      clk;
	logic      arst_n;
	logic      psel;
	logic      penable;
	logic      pwrite;
	apb_addr_t paddr;
	apb_data_t pwdata;
	apb_data_t prdata;
	logic      pready;

	tkhm_in_if  evt_ch ();
	tkhm_out_if res_ch ();

	touch_key_history_matcher dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.evt     (evt_ch),
		.res     (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// predictor state
	key_t      key_hist [HIST_LEN];
	key_t      last_key;
	apb_data_t code_shadow;

	touch_result_t pending_results [$];
	touch_row_t    row_notes [$];

	int unsigned mismatch_count;
	int unsigned results_checked;
	int unsigned events_sent;
	int unsigned match_hits;
	int unsigned gesture_hits;
	int unsigned code_settings;
	int          burst_left;
	logic        long_stall_req;

	// rows in send order; typed results only where the state is obvious
	touch_row_t plan [25] = '{
		'{3'd7, 8'hFF, 1'b1, '{1'b0, 4'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1}},
		'{3'd0, 8'h00, 1'b1, '{1'b0, 4'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1}},
		'{3'd0, 8'h01, 1'b1, '{1'b1, 4'd1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1}},
		'{3'd0, 8'h80, 1'b1, '{1'b1, 4'd8, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1}},
		'{3'd0, 8'hFF, 1'b1, '{1'b1, 4'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1}},
		'{3'd1, 8'h02, 1'b1, '{1'b0, 4'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1}},
		'{3'd2, 8'h04, 1'b1, '{1'b0, 4'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1}},
		'{3'd4, 8'h08, 1'b1, '{1'b0, 4'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1}},
		'{3'd0, 8'h08, 1'b0, '0},
		'{3'd0, 8'h04, 1'b0, '0},
		'{3'd0, 8'h02, 1'b0, '0},
		'{3'd0, 8'h01, 1'b0, '0},
		'{3'd0, 8'h01, 1'b0, '0},
		'{3'd0, 8'h02, 1'b0, '0},
		'{3'd0, 8'h04, 1'b0, '0},
		'{3'd0, 8'h08, 1'b0, '0},
		'{3'd0, 8'h80, 1'b0, '0},
		'{3'd0, 8'h40, 1'b0, '0},
		'{3'd0, 8'h20, 1'b0, '0},
		'{3'd0, 8'h10, 1'b0, '0},
		'{3'd0, 8'h10, 1'b0, '0},
		'{3'd0, 8'h20, 1'b0, '0},
		'{3'd0, 8'h40, 1'b0, '0},
		'{3'd0, 8'h80, 1'b0, '0},
		'{3'd0, 8'h03, 1'b0, '0}
	};

	// push order (oldest first) for left up, left down, right up, right down
	key_t gesture_push [4][4] = '{
		'{4'd4, 4'd3, 4'd2, 4'd1},
		'{4'd1, 4'd2, 4'd3, 4'd4},
		'{4'd8, 4'd7, 4'd6, 4'd5},
		'{4'd5, 4'd6, 4'd7, 4'd8}
	};

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic logic newest_four_are(key_t a, key_t b, key_t c, key_t d);
		return key_hist[0] == a && key_hist[1] == b && key_hist[2] == c && key_hist[3] == d;
	endfunction

	function automatic touch_result_t register_touch(fault_t fault, status_t status);
		touch_result_t r;
		key_t          k;
		key_t          nib;
		r = '0;
		if (fault == '0 && status != '0) begin
			r.key_pressed = 1'b1;
			k = '0;
			if ($countones(status) == 1) begin
				for (int b = 0; b < STATUS_W; b++)
					if (status[b])
						k = key_t'(b + 1);
			end
			last_key = k;
			for (int i = HIST_LEN - 1; i > 0; i--)
				key_hist[i] = key_hist[i - 1];
			key_hist[0] = k;
		end
		r.key_number       = last_key;
		r.slide_left_up    = newest_four_are(4'd1, 4'd2, 4'd3, 4'd4);
		r.slide_left_down  = newest_four_are(4'd4, 4'd3, 4'd2, 4'd1);
		r.slide_right_up   = newest_four_are(4'd5, 4'd6, 4'd7, 4'd8);
		r.slide_right_down = newest_four_are(4'd8, 4'd7, 4'd6, 4'd5);
		r.code_match       = 1'b1;
		for (int i = 0; i < CODE_NIBBLES; i++) begin
			nib = code_shadow[4*i +: 4];
			if (nib != '0 && nib != key_hist[i])
				r.code_match = 1'b0;
		end
		return r;
	endfunction

	function automatic status_t status_for_key(key_t k);
		status_t s;
		if (k == '0) begin
			do
				s = status_t'($urandom_range(0, 255));
			while ($countones(s) < 2);
		end else begin
			s = status_t'(1 << (k - 1));
		end
		return s;
	endfunction

	function automatic apb_data_t sparse_code();
		apb_data_t c;
		c = '0;
		for (int i = 0; i < CODE_NIBBLES; i++)
			if ($urandom_range(0, 2) != 0)
				c[4*i +: 4] = key_t'($urandom_range(1, 8));
		return c;
	endfunction

	task automatic flag_mismatch(string what, int got, int want);
		$display("MISMATCH %s: got %0d, expected %0d (result %0d, t=%0t)",
			what, got, want, results_checked, $time);
		mismatch_count++;
	endtask

	task automatic apb_write(apb_addr_t addr, apb_data_t data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (pready !== 1'b1);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if ((addr >> 2) == REG_SECRET_CODE)
			code_shadow = data;
		@(posedge clk);
	endtask

	task automatic apb_read_check(apb_addr_t addr, apb_data_t want);
		apb_data_t got;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= addr;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (pready !== 1'b1);
		got = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		if (got !== want)
			flag_mismatch("secret_code readback", int'(got), int'(want));
		@(posedge clk);
	endtask

	// offer one event; the sender runs in bursts separated by random gaps
	task automatic send_event(fault_t fault, status_t status, logic typed, touch_result_t want);
		int gap;
		row_notes.push_back(touch_row_t'{fault, status, typed, want});
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				evt_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		evt_ch.valid        <= 1'b1;
		evt_ch.fault_flags  <= fault;
		evt_ch.touch_status <= status;
		do
			@(posedge clk);
		while (evt_ch.ready !== 1'b1);
		burst_left--;
		events_sent++;
	endtask

	task automatic offer_key(key_t k);
		send_event('0, status_for_key(k), 1'b0, '0);
	endtask

	task automatic offer_noise();
		fault_t f;
		f = ($urandom_range(0, 3) == 0) ? fault_t'($urandom_range(1, 7)) : '0;
		send_event(f, status_t'($urandom_range(0, 255)), 1'b0, '0);
	endtask

	// events that leave the history alone: faulty or no pad touched
	task automatic offer_quiet();
		if ($urandom_range(0, 1) == 0)
			send_event(fault_t'($urandom_range(1, 7)), status_t'($urandom_range(0, 255)),
				1'b0, '0);
		else
			send_event('0, '0, 1'b0, '0);
	endtask

	// push the keys of the code oldest first, with the odd wrong key or pause
	task automatic offer_code_run(apb_data_t code);
		key_t nib;
		key_t k;
		for (int i = CODE_NIBBLES - 1; i >= 0; i--) begin
			nib = code[4*i +: 4];
			k = (nib >= 4'd1 && nib <= 4'd8) ? nib : key_t'($urandom_range(0, 8));
			if ($urandom_range(0, 15) == 0)
				k = key_t'($urandom_range(0, 8));
			if ($urandom_range(0, 5) == 0)
				offer_quiet();
			offer_key(k);
		end
	endtask

	task automatic offer_gesture();
		int g;
		g = $urandom_range(0, 3);
		for (int i = 0; i < 4; i++) begin
			if ($urandom_range(0, 7) == 0)
				offer_quiet();
			if ($urandom_range(0, 11) == 0)
				offer_key(key_t'($urandom_range(0, 8)));
			else
				offer_key(gesture_push[g][i]);
		end
	endtask

	// drop valid and wait for every outstanding result, plus the result stage
	task automatic drain();
		evt_ch.valid <= 1'b0;
		burst_left = 0;
		do
			@(posedge clk);
		while (pending_results.size() != 0 || row_notes.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// input side: predict at each accepted transfer
	always @(posedge clk) begin
		touch_row_t    note;
		touch_result_t p;
		if (arst_n === 1'b1 && evt_ch.valid === 1'b1 && evt_ch.ready === 1'b1) begin
			note = row_notes.pop_front();
			p = register_touch(evt_ch.fault_flags, evt_ch.touch_status);
			pending_results.push_back(note.typed ? note.want : p);
		end
	end

	// result side: compare each transfer with the oldest expectation
	always @(posedge clk) begin
		touch_result_t want;
		if (arst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			if (pending_results.size() == 0) begin
				flag_mismatch("result with nothing expected", 1, 0);
			end else begin
				want = pending_results.pop_front();
				if (res_ch.key_pressed !== want.key_pressed)
					flag_mismatch("key_pressed", res_ch.key_pressed, want.key_pressed);
				if (res_ch.key_number !== want.key_number)
					flag_mismatch("key_number", res_ch.key_number, want.key_number);
				if (res_ch.slide_left_up !== want.slide_left_up)
					flag_mismatch("slide_left_up", res_ch.slide_left_up, want.slide_left_up);
				if (res_ch.slide_left_down !== want.slide_left_down)
					flag_mismatch("slide_left_down", res_ch.slide_left_down,
						want.slide_left_down);
				if (res_ch.slide_right_up !== want.slide_right_up)
					flag_mismatch("slide_right_up", res_ch.slide_right_up,
						want.slide_right_up);
				if (res_ch.slide_right_down !== want.slide_right_down)
					flag_mismatch("slide_right_down", res_ch.slide_right_down,
						want.slide_right_down);
				if (res_ch.code_match !== want.code_match)
					flag_mismatch("code_match", res_ch.code_match, want.code_match);
				if (want.code_match && code_shadow != '0)
					match_hits++;
				if (want.slide_left_up || want.slide_left_down || want.slide_right_up
						|| want.slide_right_down)
					gesture_hits++;
				results_checked++;
			end
		end
	end

	// receiver: changing stall pattern, plus one long hold-off on request
	initial begin
		int   mode;
		int   cnt;
		logic stall_done;
		mode = 0;
		cnt = 0;
		stall_done = 1'b0;
		res_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (long_stall_req && !stall_done) begin
				stall_done = 1'b1;
				res_ch.ready <= 1'b0;
				repeat (LONG_STALL) @(posedge clk);
			end else begin
				if (cnt % 48 == 0)
					mode = $urandom_range(0, 3);
				cnt++;
				case (mode)
				0: begin
					res_ch.ready <= 1'b1;
				end
				1: begin
					res_ch.ready <= 1'($urandom_range(0, 1));
				end
				2: begin
					res_ch.ready <= (cnt % 3 == 0);
				end
				default: begin
					res_ch.ready <= ($urandom_range(0, 9) != 0);
				end
				endcase
			end
		end
	end

	initial begin
		#5_000_000;
		$display("touch_key_history_matcher test failed");
		$finish;
	end

	initial begin
		apb_data_t code;
		int        phase_end;
		int        kind;
		for (int i = 0; i < HIST_LEN; i++)
			key_hist[i] = '0;
		last_key        = '0;
		code_shadow     = '0;
		mismatch_count  = 0;
		results_checked = 0;
		events_sent     = 0;
		match_hits      = 0;
		gesture_hits    = 0;
		code_settings   = 1;
		burst_left      = 0;
		long_stall_req  = 1'b0;
		arst_n              = 1'b0;
		psel                = 1'b0;
		penable             = 1'b0;
		pwrite              = 1'b0;
		paddr               = '0;
		pwdata              = '0;
		evt_ch.valid        = 1'b0;
		evt_ch.fault_flags  = '0;
		evt_ch.touch_status = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		apb_read_check(CODE_ADDR, '0);

		foreach (plan[i])
			send_event(plan[i].fault, plan[i].status, plan[i].typed, plan[i].want);
		drain();

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
			0: code = 32'hFFFF_FFFF;
			1: code = 32'h8765_4321;
			3: code = apb_data_t'($urandom);
			PHASES - 1: code = '0;
			default: code = sparse_code();
			endcase
			apb_write(CODE_ADDR, code);
			code_settings++;
			apb_read_check(CODE_ADDR, code_shadow);
			if (phase % 2 == 1) begin
				apb_write(SPARE_ADDR, apb_data_t'($urandom));
				apb_read_check(CODE_ADDR, code_shadow);
			end
			// hold the result side off long enough to back up the input
			if (phase == 2)
				long_stall_req = 1'b1;
			phase_end = events_sent + PHASE_EVENTS;
			while (events_sent < phase_end) begin
				kind = $urandom_range(0, 9);
				if (kind < 4)
					offer_code_run(code_shadow);
				else if (kind < 6)
					offer_gesture();
				else
					offer_noise();
			end
			drain();
		end

		$display("Run covered %0d touch events and %0d checked results under %0d code settings.",
			events_sent, results_checked, code_settings);
		$display("Non-trivial code matches: %0d, slide gestures: %0d, mismatches: %0d.",
			match_hits, gesture_hits, mismatch_count);
		if (mismatch_count == 0)
			$display("touch_key_history_matcher test passed");
		else
			$display("touch_key_history_matcher test failed");
		$finish;
	end

endmodule
